/* hw/rtl/sktbl_pkg.sv */
// Package: widths, status and command codes for the sorted key table.
`default_nettype none
package sktbl_pkg;

	localparam int KEY_W        = 64;
	localparam int PAY_W        = 32;
	localparam int POS_W        = 8;
	localparam int TOTAL_W      = 9;
	localparam int STATUS_W     = 3;
	localparam int DEF_CAPACITY = 256;
	localparam int S_TDATA_W    = KEY_W + PAY_W;
	localparam int M_FIELDS_W   = PAY_W + POS_W + TOTAL_W;
	localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_HIT       = 3'd3,
		ST_MISS      = 3'd4
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
	} entry_t;

endpackage
`default_nettype wire

/* hw/rtl/sorted_key_table_insert_lookup.sv */
// Top level: sorted key table with binary-search insert and exact lookup.
//
// Channel  Dir  Handshake          Contents
// s_*      in   tvalid/tready      tuser: command; tdata: key, payload
// m_*      out  tvalid/tready      tuser: status; tdata: found_payload, position, entry_total
//
// Entries sit in one single-port-read, single-port-write memory with a registered read.
// Lookup or duplicate: the binary search, then the response.
// Insert: the search, then a read and a write per entry moved up, then the new entry is written.
// Each search step is one memory read and one key compare.
// Reset clears the entry count and control; memory contents are not cleared.
// One transaction at a time; the next is taken while the last result waits on m_tready.
`default_nettype none
module sorted_key_table_insert_lookup
	import sktbl_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire                  s_tuser,   // [0] command
	input  wire  [S_TDATA_W-1:0] s_tdata,   // [63:0] key, [95:64] payload
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [STATUS_W-1:0]  m_tuser,   // [2:0] status
	output logic [M_TDATA_W-1:0] m_tdata    // [31:0] found_payload, [39:32] position,
	                                        // [48:40] entry_total, rest zero
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		IDLE,
		SEARCH,
		CMP,
		HITCHK,
		SHRD,
		SHWR,
		WRNEW,
		RESP
	} state_t;

	state_t             state_q;
	logic               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [PAY_W-1:0]   pay_q;
	logic [CNT_W-1:0]   lo_q, hi_q, mid_q, idx_q, count_q;
	logic               lo_in_q;
	status_t            res_status_q;
	logic [PAY_W-1:0]   res_pay_q;
	logic [IDX_W-1:0]   res_pos_q;
	logic               m_tvalid_q;
	status_t            m_status_q;
	logic [PAY_W-1:0]   m_pay_q;
	logic [POS_W-1:0]   m_pos_q;
	logic [TOTAL_W-1:0] m_total_q;

	entry_t             mem [CAPACITY];
	entry_t             rd_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               we;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	logic [CNT_W-1:0]   mid;
	logic [CNT_W-1:0]   idx_m1;
	logic               hit;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_m1 = idx_q - 1'b1;
	assign hit    = lo_in_q && (rd_q.key == key_q);

	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		case (state_q)
			SEARCH: begin
				rd_addr = (lo_q < hi_q) ? mid[IDX_W-1:0] : lo_q[IDX_W-1:0];
			end
			SHRD: begin
				rd_addr = idx_m1[IDX_W-1:0];
			end
			SHWR: begin
				we      = 1'b1;
				wr_addr = idx_q[IDX_W-1:0];
				wr_data = rd_q;
			end
			WRNEW: begin
				we          = 1'b1;
				wr_addr     = lo_q[IDX_W-1:0];
				wr_data.key = key_q;
				wr_data.pay = pay_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						key_q   <= s_tdata[KEY_W-1:0];
						pay_q   <= s_tdata[S_TDATA_W-1:KEY_W];
						lo_q    <= '0;
						hi_q    <= count_q;
						state_q <= SEARCH;
					end
				end
				SEARCH: begin
					mid_q   <= mid;
					lo_in_q <= (lo_q < count_q);
					state_q <= (lo_q < hi_q) ? CMP : HITCHK;
				end
				CMP: begin
					if (rd_q.key < key_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= SEARCH;
				end
				HITCHK: begin
					if (hit) begin
						res_status_q <= (cmd_q == CMD_LOOKUP) ? ST_HIT : ST_DUPLICATE;
						res_pay_q    <= rd_q.pay;
						res_pos_q    <= lo_q[IDX_W-1:0];
						state_q      <= RESP;
					end else if (cmd_q == CMD_LOOKUP) begin
						res_status_q <= ST_MISS;
						res_pay_q    <= '0;
						res_pos_q    <= '0;
						state_q      <= RESP;
					end else if (count_q >= CNT_W'(CAPACITY)) begin
						res_status_q <= ST_FULL;
						res_pay_q    <= '0;
						res_pos_q    <= '0;
						state_q      <= RESP;
					end else begin
						idx_q   <= count_q;
						state_q <= (count_q > lo_q) ? SHRD : WRNEW;
					end
				end
				SHRD: begin
					state_q <= SHWR;
				end
				SHWR: begin
					idx_q   <= idx_m1;
					state_q <= (idx_m1 > lo_q) ? SHRD : WRNEW;
				end
				WRNEW: begin
					count_q      <= count_q + 1'b1;
					res_status_q <= ST_INSERTED;
					res_pay_q    <= '0;
					res_pos_q    <= lo_q[IDX_W-1:0];
					state_q      <= RESP;
				end
				RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_pay_q    <= res_pay_q;
						m_pos_q    <= POS_W'(res_pos_q);
						m_total_q  <= TOTAL_W'(count_q);
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), m_total_q, m_pos_q, m_pay_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
		else $error("entry count changed by other than one");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEARCH) |-> ((lo_q <= hi_q) && (hi_q <= count_q)))
		else $error("search window out of order");

endmodule
`default_nettype wire
